// ===== rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the radix text converter.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is checked through reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/itrt_pkg.sv =====
// -----------------------------------------------------------------------------
// itrt_pkg
// Shared types and constants of the radix text converter.
// -----------------------------------------------------------------------------
package itrt_pkg;

    // Default width of the converted value.
    localparam int DEFAULT_VALUE_BITS = 32;

    // Width of one stored digit; remainders stay below the largest base.
    localparam int DIGIT_BITS = 6;

    localparam logic [7:0] BASE_MIN = 8'd2;
    localparam logic [7:0] BASE_MAX = 8'd35;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;

    // Control handed from the sequencer to the divider.
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // Status returned by the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/itrt_ram.sv =====
// -----------------------------------------------------------------------------
// itrt_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/itrt_divider.sv =====
// -----------------------------------------------------------------------------
// itrt_divider
// Bit-serial restoring divider of the magnitude by the base, one bit a cycle.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module itrt_divider
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctrl             i_ctrl,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [DIGIT_BITS-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [DIGIT_BITS-1:0] o_remainder
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [DIGIT_BITS-1:0] r_rem, n_rem;
    logic [DIGIT_BITS-1:0] r_div, n_div;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [DIGIT_BITS:0] w_trial;
    logic [DIGIT_BITS:0] w_diff;
    logic                w_ge;

    // The trial remainder brings in the next dividend bit from the top.
    assign w_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quo = {r_quo[VALUE_BITS-2:0], w_ge};
            n_rem = w_ge ? w_diff[DIGIT_BITS-1:0] : w_trial[DIGIT_BITS-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    // A finished division always leaves a remainder below the divisor.
    `ASSERT_CLK(a_rem_below_div, i_clk, i_rst_n, r_done |-> (r_rem < r_div), "remainder not below divisor")
    // Done rises together with the fall of busy, at the end of the busy phase.
    `ASSERT_CLK(a_done_after_busy, i_clk, i_rst_n, r_done |-> ($past(r_busy) && !r_busy), "done without a busy phase")

endmodule

// ===== rtl/integer_to_radix_text.sv =====
// -----------------------------------------------------------------------------
// integer_to_radix_text
// Converts a signed integer to ASCII text in a base from 2 to 35.
// -----------------------------------------------------------------------------
// Each request carries a signed value and a base. The block answers with the
// value as text, one character per output request in reading order: a '-'
// first for a negative value, then the digits of the magnitude from the most
// significant, using 0-9 and then a-y, with o_last set on the final character.
// The most negative value is converted exactly as a magnitude of
// 2^(VALUE_BITS-1), and zero gives the single character '0'. A base below 2
// or above 35 gives a single character of 0 with both o_last and o_empty_res
// set. The block works on one request at a time and takes no new request
// until the last character has been loaded into its output register; that
// register lets the next request in while the final character still waits.
// Digits come from a shared bit-serial divider, which sets the conversion
// time; output characters are paced by the registered read of the digit
// store, which each character waits for in S_READ before S_EMIT.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_radix_text
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [7:0]            i_base,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_character,
    output logic                  o_last,
    output logic                  o_empty_res
);

    // The digit count must hold VALUE_BITS itself; the store index need not.
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SIGN  = 6'b000100,
        S_READ  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_EMPTY = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Digit count: counts up while digits are produced, down while sent.
    logic [CW-1:0] r_count, n_count;
    logic          r_neg, n_neg;

    // Base of the request in progress, held for every later division.
    logic [DIGIT_BITS-1:0] r_base, n_base;

    // Output register.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       r_empty, n_empty;

    logic                  w_base_ok;
    logic                  w_sign;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_out_free;
    logic [CW-1:0]         w_rd_idx;
    logic [7:0]            w_digit_char;

    t_div_ctrl             w_div_ctrl;
    t_div_stat             w_div_stat;
    logic [VALUE_BITS-1:0] w_dividend;
    logic [DIGIT_BITS-1:0] w_divisor;
    logic [VALUE_BITS-1:0] w_quotient;
    logic [DIGIT_BITS-1:0] w_remainder;

    logic                  w_ram_we;
    logic [DIGIT_BITS-1:0] w_ram_rdata;

    assign w_base_ok = i_base inside {[BASE_MIN:BASE_MAX]};
    assign w_sign    = i_value[VALUE_BITS-1];
    // Two's complement negation wraps the most negative value onto itself,
    // which read unsigned is exactly its magnitude.
    assign w_mag     = w_sign ? (~i_value + 1'b1) : i_value;

    // The first division takes the base straight from the request; the
    // following ones use the copy held since the request was accepted.
    assign w_divisor = (r_state == S_IDLE) ? i_base[DIGIT_BITS-1:0] : r_base;

    // The output register can take a character when it is empty or draining.
    assign w_out_free = !r_out_valid || i_ready;

    // The store is read continuously at the next digit to send.
    assign w_rd_idx = r_count - 1'b1;

    assign w_digit_char = (w_ram_rdata < DIGIT_BITS'(10))
        ? (CHAR_ZERO + {2'b00, w_ram_rdata})
        : (CHAR_A + {2'b00, w_ram_rdata} - 8'd10);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_neg       = r_neg;
        n_base      = r_base;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_empty     = r_empty;
        w_div_ctrl  = '0;
        w_dividend  = w_quotient;
        w_ram_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (w_base_ok) begin
                        n_neg            = w_sign;
                        n_base           = i_base[DIGIT_BITS-1:0];
                        n_count          = '0;
                        w_div_ctrl.start = 1'b1;
                        w_dividend       = w_mag;
                        n_state          = S_DIV;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    // Store this digit and keep dividing while anything is left.
                    w_ram_we = 1'b1;
                    n_count  = r_count + 1'b1;
                    if (w_quotient == '0) begin
                        n_state = r_neg ? S_SIGN : S_READ;
                    end else begin
                        w_div_ctrl.start = 1'b1;
                    end
                end
            end
            S_SIGN: begin
                // At least one digit always follows the sign.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = MINUS_CHAR;
                    n_last      = 1'b0;
                    n_empty     = 1'b0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = w_digit_char;
                    n_last      = (r_count == CW'(1));
                    n_empty     = 1'b0;
                    n_count     = w_rd_idx;
                    n_state     = (r_count == CW'(1)) ? S_IDLE : S_READ;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_empty     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
        r_base  <= n_base;
        r_char  <= n_char;
        r_last  <= n_last;
        r_empty <= n_empty;
    end

    itrt_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_div_ctrl),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    itrt_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_BITS),
        .AW    (AW)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_remainder),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

    // A digit is never written past the end of the store.
    `ASSERT_CLK(a_store_in_range, i_clk, i_rst_n, w_ram_we |-> (r_count < CW'(VALUE_BITS)), "digit store overflow")
    // A request with a valid base starts the divider on the next cycle.
    `ASSERT_CLK(a_accept_starts_div, i_clk, i_rst_n, (i_valid && o_ready && w_base_ok) |=> w_div_stat.busy, "divider not started")
    // The block is never open for a request while the divider still runs.
    `ASSERT_CLK(a_idle_div_quiet, i_clk, i_rst_n, o_ready |-> !w_div_stat.busy, "ready while dividing")

endmodule

// ===== sim/integer_to_radix_text_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// integer_to_radix_text_tb
// Self-checking bench for the signed integer to radix text converter.
// -----------------------------------------------------------------------------
// Conversion requests are queued up front by the stimulus block: a short
// directed set covering the value and base extremes, the sign, zero and the
// invalid bases, followed by a long random set. A clocked driver presents
// the queued requests and a clocked monitor takes the output characters.
// Every accepted request is expanded on the spot into the characters it
// should produce, and each output character is checked against the oldest
// one still waiting. The run steps through idling phases on both sides.
// -----------------------------------------------------------------------------

module integer_to_radix_text_tb;
    import itrt_pkg::*;

    // Number of random requests after the directed set.
    localparam int RANDOM_REQS = 310;
    // Cycles to keep watching the output after the last expected character.
    localparam int DRAIN_CYCLES = 1200;

    // One conversion request as queued by the stimulus block. The phase
    // selects how often each side of the handshake idles while it is sent.
    typedef struct {
        logic [31:0] value;
        logic [7:0]  base;
        int          phase;
    } t_conversion_req;

    // One output character as the converter should present it.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       empty_res;
    } t_text_char;

    // Idle percentages per phase: none, sender idle, receiver stalling, both.
    int unsigned send_idle_pct[4]  = '{0, 71, 0, 16};
    int unsigned recv_stall_pct[4] = '{0, 0, 71, 16};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [31:0] i_value     = '0;
    logic [7:0]  i_base      = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;
    logic        o_empty_res;

    t_conversion_req pending_reqs[$];
    t_text_char      expected_text[$];
    int              stim_phase  = 0;
    int              error_count = 0;

    integer_to_radix_text #(
        .VALUE_BITS (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_base      (i_base),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Counts a failure; only the first few are described in the log.
    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch %0d: %s", error_count, what);
        end
    endtask

    task automatic queue_req(input logic [31:0] value, input logic [7:0] base,
                             input int phase);
        t_conversion_req rq;
        rq.value = value;
        rq.base  = base;
        rq.phase = phase;
        pending_reqs.push_back(rq);
    endtask

    // Expands one accepted request into the characters it must produce.
    // The digits are found least significant first by repeated division,
    // then sent most significant first behind an optional minus sign.
    function automatic void predict_text(input logic [31:0] value,
                                         input logic [7:0] base);
        logic [31:0] mag;
        logic [31:0] rem;
        logic [5:0]  digits[32];
        logic        neg;
        int          n;
        t_text_char  tc;
        if (base < BASE_MIN || base > BASE_MAX) begin
            // An unusable base answers with one empty, final character.
            tc.character = 8'h00;
            tc.last      = 1'b1;
            tc.empty_res = 1'b1;
            expected_text.push_back(tc);
            return;
        end
        neg = value[31];
        // Negating the most negative value wraps to 2^31, which is exactly
        // the magnitude wanted when read as unsigned.
        mag = neg ? (~value + 32'd1) : value;
        n = 0;
        do begin
            rem = mag % base;
            mag = mag / base;
            digits[n] = rem[5:0];
            n++;
        end while (mag != 0);
        tc.empty_res = 1'b0;
        if (neg) begin
            // At least one digit always follows the sign.
            tc.character = MINUS_CHAR;
            tc.last      = 1'b0;
            expected_text.push_back(tc);
        end
        for (int i = n - 1; i >= 0; i--) begin
            tc.character = (digits[i] < 6'd10) ? CHAR_ZERO + 8'(digits[i])
                                               : CHAR_A + 8'(digits[i]) - 8'd10;
            tc.last      = (i == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Request driver. A request is predicted at the edge where it is
    // accepted. A new one is loaded either into an idle channel or straight
    // behind an accepted one; valid is lowered when none is loaded in its place.
    always @(posedge i_clk) begin
        t_conversion_req rq;
        logic accepted;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) begin
                predict_text(i_value, i_base);
            end
            if ((!i_valid || accepted) && pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct[stim_phase]) begin
                rq = pending_reqs.pop_front();
                i_value    <= rq.value;
                i_base     <= rq.base;
                i_valid    <= 1'b1;
                stim_phase <= rq.phase;
            end else if (accepted) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side back pressure, following the phase of the last request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct[stim_phase]);
        end
    end

    // Output monitor: every accepted character is matched against the
    // oldest expected one, field by field.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_text.size() == 0) begin
                report_error($sformatf("unexpected character %h last %b empty %b",
                                       o_character, o_last, o_empty_res));
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.character || o_last !== want.last ||
                    o_empty_res !== want.empty_res) begin
                    report_error($sformatf(
                        "expected char %h last %b empty %b, got char %h last %b empty %b",
                        want.character, want.last, want.empty_res,
                        o_character, o_last, o_empty_res));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int          kind;
        int          phase_order[4];
        logic [31:0] val;
        logic [7:0]  base;

        // Directed set, sent without idling. It covers zero, both sign
        // extremes, the largest digit count in base 2, the highest digit in
        // the largest base, carries into a new digit, and the unusable bases
        // at both ends of the base field.
        queue_req(32'd0,          8'd10, 0);
        queue_req(32'd0,          8'd2,  0);
        queue_req(32'h7FFF_FFFF,  8'd2,  0);
        queue_req(32'h8000_0000,  8'd2,  0);
        queue_req(32'h8000_0000,  8'd35, 0);
        queue_req(32'h8000_0000,  8'd10, 0);
        queue_req(32'h7FFF_FFFF,  8'd35, 0);
        queue_req(32'hFFFF_FFFF,  8'd10, 0);
        queue_req(32'hFFFF_FFFF,  8'd2,  0);
        queue_req(32'd34,         8'd35, 0);
        queue_req(32'd35,         8'd35, 0);
        queue_req(32'd7,          8'd35, 0);
        queue_req(32'd1,          8'd2,  0);
        queue_req(32'd255,        8'd16, 0);
        queue_req(32'd12345,      8'd10, 0);
        queue_req(32'd123456789,  8'd34, 0);
        queue_req(32'h5555_5555,  8'd2,  0);
        queue_req(32'hAAAA_AAAA,  8'd3,  0);
        queue_req(32'd12345,      8'd0,  0);
        queue_req(32'hFFFF_CFC7,  8'd1,  0);
        queue_req(32'h8000_0000,  8'd36, 0);
        queue_req(32'hFFFF_FFFF,  8'd255, 0);

        // Random set in four phases: sender idle, receiver stalling, both,
        // and a final stretch with no idling at all.
        phase_order = '{1, 2, 3, 0};
        for (int i = 0; i < RANDOM_REQS; i++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                val = $urandom;
            end else if (kind == 5) begin
                val = $urandom_range(0, 100);
            end else if (kind == 6) begin
                val = -$urandom_range(1, 100);
            end else if (kind == 7) begin
                case ($urandom_range(0, 3))
                    0: begin
                        val = 32'd0;
                    end
                    1: begin
                        val = 32'h8000_0000;
                    end
                    2: begin
                        val = 32'h7FFF_FFFF;
                    end
                    default: begin
                        val = 32'hFFFF_FFFF;
                    end
                endcase
            end else begin
                // Spread of magnitudes, either sign.
                val = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    val = -val;
                end
            end
            if ($urandom_range(0, 9) < 8) begin
                base = 8'($urandom_range(2, 35));
            end else if ($urandom_range(0, 1) == 1) begin
                base = 8'($urandom_range(0, 1));
            end else begin
                base = 8'($urandom_range(36, 255));
            end
            queue_req(val, base, phase_order[(i * 4) / RANDOM_REQS]);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone in and every character has come
        // out, then watch a while longer for stray output.
        while (pending_reqs.size() != 0 || i_valid || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
